// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the renderer's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== hdl/tsr_pkg.sv =====
// Package with the types, constants and helper functions of the scanline renderer.
`default_nettype none

package tsr_pkg;

   // Default values of the top-level parameters.
   localparam int LINE_PIXELS_DEF       = 160;
   localparam int VISIBLE_LINES_DEF     = 144;
   localparam int SPRITE_ENTRIES_DEF    = 40;
   localparam int SPRITES_ON_LINE_DEF   = 10;
   localparam int PIXELS_PER_RESULT_DEF = 8;

   // Tile memory is fixed in size.
   localparam int TILE_MEM_BYTES = 8192;
   localparam int TILE_AW        = 13;

   localparam logic [TILE_AW-1:0] MAP_LOW          = 13'h1800;
   localparam logic [TILE_AW-1:0] MAP_HIGH         = 13'h1C00;
   localparam logic [TILE_AW-1:0] DATA_SIGNED_BASE = 13'h0800;
   localparam int                 WINDOW_LEFT_MAX  = 167;

   // Register indexes on the csr port.
   localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
   localparam logic [2:0] REG_SCROLL_Y    = 3'd1;
   localparam logic [2:0] REG_SCROLL_X    = 3'd2;
   localparam logic [2:0] REG_WINDOW_TOP  = 3'd3;
   localparam logic [2:0] REG_WINDOW_LEFT = 3'd4;
   localparam logic [2:0] REG_BG_PALETTE  = 3'd5;
   localparam logic [2:0] REG_OBJ_PAL0    = 3'd6;
   localparam logic [2:0] REG_OBJ_PAL1    = 3'd7;

   // Bit positions in lcd_control.
   localparam int LCDC_DISPLAY  = 7;
   localparam int LCDC_WIN_MAP  = 6;
   localparam int LCDC_WIN_ON   = 5;
   localparam int LCDC_UNSIGNED = 4;
   localparam int LCDC_BG_MAP   = 3;
   localparam int LCDC_OBJ_TALL = 2;
   localparam int LCDC_OBJ_ON   = 1;
   localparam int LCDC_BG_ON    = 0;

   // Bit positions in a sprite's flag byte.
   localparam int OBJ_BEHIND = 7;
   localparam int OBJ_YFLIP  = 6;
   localparam int OBJ_XFLIP  = 5;
   localparam int OBJ_PAL1   = 4;

   typedef enum logic [1:0] {
      MODE_TILE_WR   = 2'd0,
      MODE_SPRITE_WR = 2'd1,
      MODE_RENDER    = 2'd2,
      MODE_FRAME     = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [12:0] address;
      logic [7:0]  data;
      logic [7:0]  line;
   } req_type;

   typedef struct packed {
      logic [4:0]  group;
      logic [15:0] shades;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] flags;
      logic [7:0] tile;
      logic [7:0] x;
      logic [7:0] y;
   } sprite_entry_type;

   typedef struct packed {
      logic             clear;
      logic             push;
      sprite_entry_type entry;
   } sprite_ctrl_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PIX,
      S_PIX_IDX,
      S_PIX_LO,
      S_PIX_HI,
      S_SCAN,
      S_OBJ_FETCH,
      S_OBJ_LO,
      S_OBJ_HI,
      S_OBJ_PX,
      S_OBJ_WR,
      S_OUT
   } state_type;

   function automatic logic [1:0] pick_bit(input logic [7:0] lo, input logic [7:0] hi,
                                           input logic [2:0] pos);
      pick_bit = {hi[pos], lo[pos]};
   endfunction

   function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] c);
      pal_shade = pal[2*c +: 2];
   endfunction

   // Address of the low byte of a background or window tile row.
   function automatic logic [TILE_AW-1:0] bg_tile_addr(input logic unsigned_mode,
                                                       input logic [7:0] idx,
                                                       input logic [2:0] row);
      logic [TILE_AW-1:0] off;
      off = {1'b0, idx, row, 1'b0};
      if (unsigned_mode) begin
         bg_tile_addr = off;
      end else begin
         bg_tile_addr = DATA_SIGNED_BASE + {1'b0, idx ^ 8'h80, row, 1'b0};
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tile_sprite_scanline_renderer_unit.sv =====
// Top level of the tile and sprite scanline renderer.
//
//  channel   ports                               direction  handshake
//  request   start, busy, req_item               in         start while busy is low
//  result    rsp_valid, rsp_item                 out        one-cycle strobe, no stall
//  csr       csr_we, csr_index, csr_wdata        in         write at any clock edge
//
// After reset the block sweeps tile and sprite memory to zero, one byte a cycle; busy
// stays high meanwhile. A tile or sprite write, a frame start and a render of an
// invisible line complete without leaving the idle state. A render with the display
// off goes straight to the output sweep. With the display on it runs the layer pass,
// which fetches tiles, then, with sprites enabled, the sprite scan (one sprite memory
// port) and the sprite draw for the sprites found (one line buffer port), then the
// output sweep.
// Results leave through a register; the receiver cannot stall them.
`default_nettype none
`include "assert_macros.svh"

module tile_sprite_scanline_renderer_unit #(
   parameter int LINE_PIXELS       = tsr_pkg::LINE_PIXELS_DEF,
   parameter int VISIBLE_LINES     = tsr_pkg::VISIBLE_LINES_DEF,
   parameter int SPRITE_ENTRIES    = tsr_pkg::SPRITE_ENTRIES_DEF,
   parameter int SPRITES_ON_LINE   = tsr_pkg::SPRITES_ON_LINE_DEF,
   parameter int PIXELS_PER_RESULT = tsr_pkg::PIXELS_PER_RESULT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tsr_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output tsr_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import tsr_pkg::*;

   localparam int GROUPS = (LINE_PIXELS + PIXELS_PER_RESULT - 1) / PIXELS_PER_RESULT;
   localparam int XW     = $clog2(LINE_PIXELS + 1);
   localparam int LBW    = $clog2(LINE_PIXELS);
   localparam int SBYTES = SPRITE_ENTRIES * 4;
   localparam int SAW    = $clog2(SBYTES);
   localparam int IW     = $clog2(SPRITE_ENTRIES + 1);
   localparam int CW     = $clog2(SPRITES_ON_LINE + 1);
   localparam int LW     = (SPRITES_ON_LINE > 1) ? $clog2(SPRITES_ON_LINE) : 1;
   localparam int GW     = $clog2(GROUPS + 1);
   localparam int OXW    = $clog2(GROUPS * PIXELS_PER_RESULT + 1);
   localparam int PW     = $clog2(PIXELS_PER_RESULT + 1);
   localparam int PKW    = 2 * PIXELS_PER_RESULT;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [7:0] lcdc_ff, scy_ff, scx_ff, wtop_ff, wl7_ff, bgp_ff, obp0_ff, obp1_ff;
   logic [7:0] wcount_ff;

   // Render working registers.
   logic [7:0]         line_ff;
   logic               blank_ff;
   logic               win_act_ff;
   logic [7:0]         wy_ff;
   logic [XW-1:0]      x_ff;
   logic               tag_valid_ff;
   logic [5:0]         tag_ff;
   logic [7:0]         lo_ff, hi_ff;
   logic [TILE_AW-1:0] taddr_ff;
   logic [TILE_AW-1:0] clr_ff;
   logic [IW-1:0]      i_ff;
   logic [2:0]         b_ff;
   logic [23:0]        ent_ff;
   logic [CW-1:0]      d_ff;
   logic [3:0]         px_ff;
   logic [7:0]         sx_ff;
   logic [7:0]         obj_pal_ff;
   logic               behind_ff;
   logic               xflip_ff;
   logic [LBW-1:0]     lbaddr_ff;
   logic [1:0]         color_ff;
   logic [GW-1:0]      g_ff;
   logic [PW-1:0]      p_ff;
   logic [OXW-1:0]     ox_ff;
   logic               pend_ff;
   logic [PKW-1:0]     packed_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // Memory ports.
   logic               tram_we;
   logic [TILE_AW-1:0] tram_addr;
   logic [7:0]         tram_wdata, tram_rdata;
   logic               sram_we;
   logic [SAW-1:0]     sram_addr;
   logic [7:0]         sram_rdata;
   logic               lb_we;
   logic [LBW-1:0]     lb_addr;
   logic [3:0]         lb_wdata, lb_rdata;

   sprite_ctrl_type    list_ctrl;
   sprite_entry_type   list_entry;
   logic [CW-1:0]      list_count;
   logic [LW-1:0]      list_sel;

   tsr_ram #(.WIDTH(8), .DEPTH(TILE_MEM_BYTES)) u_tile_ram (
      .clock(clock), .we(tram_we), .addr(tram_addr), .wdata(tram_wdata), .rdata(tram_rdata)
   );

   tsr_ram #(.WIDTH(8), .DEPTH(SBYTES)) u_sprite_ram (
      .clock(clock), .we(sram_we), .addr(sram_addr), .wdata(tram_wdata), .rdata(sram_rdata)
   );

   // Line buffer entry: background index in the upper two bits, shade in the lower two.
   tsr_ram #(.WIDTH(4), .DEPTH(LINE_PIXELS)) u_line_ram (
      .clock(clock), .we(lb_we), .addr(lb_addr), .wdata(lb_wdata), .rdata(lb_rdata)
   );

   tsr_sprite_list #(.SLOTS(SPRITES_ON_LINE)) u_list (
      .clock(clock), .reset(reset), .ctrl(list_ctrl), .rd_index(list_sel),
      .rd_entry(list_entry), .count(list_count)
   );

   // Request decode.
   logic accept, render_go, win_act;
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign render_go = accept && (req_item.mode == MODE_RENDER)
                      && (req_item.line < 8'(VISIBLE_LINES));
   assign win_act   = lcdc_ff[LCDC_WIN_ON] && (wtop_ff <= req_item.line)
                      && (wl7_ff < 8'(WINDOW_LEFT_MAX));

   // Layer pass: the window covers pixels from its left edge on, otherwise background.
   logic               use_win, layer_on, tag_hit, x_done;
   logic [7:0]         x8, mx, my;
   logic [TILE_AW-1:0] map_base, map_addr, bg_data_addr;
   logic [1:0]         pix_c;
   assign x8       = 8'(x_ff);
   assign use_win  = win_act_ff && ((10'(x_ff) + 10'd7) >= 10'(wl7_ff));
   assign mx       = use_win ? (x8 + 8'd7 - wl7_ff) : (x8 + scx_ff);
   assign my       = use_win ? wy_ff : (line_ff + scy_ff);
   assign layer_on = use_win || lcdc_ff[LCDC_BG_ON];
   assign tag_hit  = tag_valid_ff && (tag_ff == {use_win, mx[7:3]});
   assign x_done   = (x_ff == XW'(LINE_PIXELS));
   assign map_base = (use_win ? lcdc_ff[LCDC_WIN_MAP] : lcdc_ff[LCDC_BG_MAP]) ? MAP_HIGH
                                                                                : MAP_LOW;
   assign map_addr     = map_base + {3'b000, my[7:3], mx[7:3]};
   assign bg_data_addr = bg_tile_addr(lcdc_ff[LCDC_UNSIGNED], tram_rdata, my[2:0]);
   assign pix_c        = layer_on ? pick_bit(lo_ff, hi_ff, 3'd7 - mx[2:0]) : 2'd0;

   // Sprite scan: the entry completes when its flag byte arrives.
   sprite_entry_type cur_ent;
   logic [8:0]       l16, y9, h9;
   logic             hit, full_after, last_entry;
   logic [CW-1:0]    found;
   assign cur_ent    = {sram_rdata, ent_ff};
   assign l16        = {1'b0, line_ff} + 9'd16;
   assign y9         = {1'b0, cur_ent.y};
   assign h9         = lcdc_ff[LCDC_OBJ_TALL] ? 9'd16 : 9'd8;
   assign hit        = (b_ff == 3'd4) && (l16 >= y9) && (l16 < (y9 + h9));
   assign found      = list_count + CW'(hit);
   assign full_after = (found == CW'(SPRITES_ON_LINE));
   assign last_entry = (i_ff == IW'(SPRITE_ENTRIES - 1));

   // Sprite draw: highest-ordered sprite first so that the lowest one wins.
   logic [3:0]         srow;
   logic [7:0]         stile;
   logic [TILE_AW-1:0] obj_addr;
   logic               skip;
   logic [8:0]         pos9;
   logic               on_line;
   logic [1:0]         sc;
   assign list_sel = LW'(d_ff - 1'b1);
   always_comb begin
      srow  = 4'(l16 - {1'b0, list_entry.y});
      stile = list_entry.tile;
      if (list_entry.flags[OBJ_YFLIP]) begin
         srow = (lcdc_ff[LCDC_OBJ_TALL] ? 4'd15 : 4'd7) - srow;
      end
      if (lcdc_ff[LCDC_OBJ_TALL]) begin
         stile = {list_entry.tile[7:1], srow[3]};
      end
   end
   assign obj_addr = {1'b0, stile, srow[2:0], 1'b0};
   assign skip     = (list_entry.x == 8'd0) || ({1'b0, list_entry.x} >= 9'(LINE_PIXELS + 8));
   assign pos9     = {1'b0, sx_ff} + 9'(px_ff);
   assign on_line  = (pos9 >= 9'd8) && ((pos9 - 9'd8) < 9'(LINE_PIXELS));
   assign sc       = pick_bit(lo_ff, hi_ff, xflip_ff ? px_ff[2:0] : (3'd7 - px_ff[2:0]));

   // Output sweep.
   logic           p_end, g_end;
   logic [1:0]     out_val;
   logic [PKW-1:0] packed_next;
   assign p_end       = (p_ff == PW'(PIXELS_PER_RESULT));
   assign g_end       = (g_ff == GW'(GROUPS - 1));
   assign out_val     = pend_ff ? (blank_ff ? bgp_ff[1:0] : lb_rdata[1:0]) : 2'd0;
   assign packed_next = PKW'({packed_ff, out_val});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == TILE_AW'(TILE_MEM_BYTES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (render_go) state_in = lcdc_ff[LCDC_DISPLAY] ? S_PIX : S_OUT;
         end
         S_PIX: begin
            if (x_done) begin
               state_in = lcdc_ff[LCDC_OBJ_ON] ? S_SCAN : S_OUT;
            end else if (layer_on && !tag_hit) begin
               state_in = S_PIX_IDX;
            end
         end
         S_PIX_IDX: state_in = S_PIX_LO;
         S_PIX_LO:  state_in = S_PIX_HI;
         S_PIX_HI:  state_in = S_PIX;
         S_SCAN: begin
            if (b_ff == 3'd4 && (full_after || last_entry)) begin
               state_in = (found == '0) ? S_OUT : S_OBJ_FETCH;
            end
         end
         S_OBJ_FETCH: begin
            if (!skip) begin
               state_in = S_OBJ_LO;
            end else if (d_ff == CW'(1)) begin
               state_in = S_OUT;
            end
         end
         S_OBJ_LO: state_in = S_OBJ_HI;
         S_OBJ_HI: state_in = S_OBJ_PX;
         S_OBJ_PX: begin
            if (px_ff == 4'd8) begin
               state_in = (d_ff == CW'(1)) ? S_OUT : S_OBJ_FETCH;
            end else if (on_line && sc != 2'd0) begin
               state_in = S_OBJ_WR;
            end
         end
         S_OBJ_WR: state_in = S_OBJ_PX;
         S_OUT: begin
            if (p_end && g_end) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory and list controls.
   always_comb begin
      tram_we    = 1'b0;
      tram_addr  = '0;
      tram_wdata = '0;
      sram_we    = 1'b0;
      sram_addr  = '0;
      lb_we      = 1'b0;
      lb_addr    = '0;
      lb_wdata   = '0;
      list_ctrl  = '0;
      case (state_ff)
         S_CLEAR: begin
            tram_we   = 1'b1;
            tram_addr = clr_ff;
            sram_we   = (clr_ff < TILE_AW'(SBYTES));
            sram_addr = SAW'(clr_ff);
         end
         S_IDLE: begin
            tram_addr  = req_item.address;
            tram_wdata = req_item.data;
            sram_addr  = SAW'(req_item.address);
            tram_we    = accept && (req_item.mode == MODE_TILE_WR);
            sram_we    = accept && (req_item.mode == MODE_SPRITE_WR)
                         && (req_item.address < 13'(SBYTES));
         end
         S_PIX: begin
            if (!x_done && layer_on && !tag_hit) begin
               tram_addr = map_addr;
            end else if (!x_done) begin
               lb_we    = 1'b1;
               lb_addr  = LBW'(x_ff);
               lb_wdata = {pix_c, pal_shade(bgp_ff, pix_c)};
            end
            list_ctrl.clear = x_done;
         end
         S_PIX_IDX: tram_addr = bg_data_addr;
         S_PIX_LO:  tram_addr = taddr_ff + 1'b1;
         S_SCAN: begin
            sram_addr            = SAW'({i_ff, b_ff[1:0]});
            list_ctrl.push       = hit;
            list_ctrl.entry      = cur_ent;
         end
         S_OBJ_FETCH: tram_addr = obj_addr;
         S_OBJ_LO:    tram_addr = taddr_ff + 1'b1;
         S_OBJ_PX:    lb_addr   = LBW'(pos9 - 9'd8);
         S_OBJ_WR: begin
            lb_addr  = lbaddr_ff;
            lb_we    = !(behind_ff && lb_rdata[3:2] != 2'd0);
            lb_wdata = {lb_rdata[3:2], pal_shade(obj_pal_ff, color_ff)};
         end
         S_OUT: lb_addr = LBW'(ox_ff);
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         lcdc_ff      <= 8'h91;
         scy_ff       <= 8'h00;
         scx_ff       <= 8'h00;
         wtop_ff      <= 8'h00;
         wl7_ff       <= 8'h00;
         bgp_ff       <= 8'hFC;
         obp0_ff      <= 8'hFF;
         obp1_ff      <= 8'hFF;
         wcount_ff    <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_OUT) && p_end;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_we) begin
            case (csr_index)
               REG_LCD_CONTROL: lcdc_ff <= csr_wdata;
               REG_SCROLL_Y:    scy_ff  <= csr_wdata;
               REG_SCROLL_X:    scx_ff  <= csr_wdata;
               REG_WINDOW_TOP:  wtop_ff <= csr_wdata;
               REG_WINDOW_LEFT: wl7_ff  <= csr_wdata;
               REG_BG_PALETTE:  bgp_ff  <= csr_wdata;
               REG_OBJ_PAL0:    obp0_ff <= csr_wdata;
               REG_OBJ_PAL1:    obp1_ff <= csr_wdata;
               default: ;
            endcase
         end
         // The window line counter advances on every displayed line that shows the window.
         if (accept && req_item.mode == MODE_FRAME) begin
            wcount_ff <= 8'h00;
         end else if (render_go && lcdc_ff[LCDC_DISPLAY] && win_act) begin
            wcount_ff <= wcount_ff + 8'h01;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            line_ff      <= req_item.line;
            blank_ff     <= !lcdc_ff[LCDC_DISPLAY];
            win_act_ff   <= win_act;
            wy_ff        <= wcount_ff;
            x_ff         <= '0;
            tag_valid_ff <= 1'b0;
         end
         S_PIX: begin
            if (!x_done && !(layer_on && !tag_hit)) x_ff <= x_ff + 1'b1;
            i_ff <= '0;
            b_ff <= '0;
         end
         S_PIX_IDX: begin
            taddr_ff     <= bg_data_addr;
            tag_ff       <= {use_win, mx[7:3]};
            tag_valid_ff <= 1'b1;
         end
         S_PIX_LO: lo_ff <= tram_rdata;
         S_PIX_HI: hi_ff <= tram_rdata;
         S_SCAN: begin
            if (b_ff != 3'd0 && b_ff != 3'd4) ent_ff[8*(2'(b_ff - 3'd1)) +: 8] <= sram_rdata;
            if (b_ff == 3'd4) begin
               b_ff <= '0;
               i_ff <= i_ff + 1'b1;
               d_ff <= found;
            end else begin
               b_ff <= b_ff + 3'd1;
            end
         end
         S_OBJ_FETCH: begin
            if (skip) begin
               d_ff <= d_ff - 1'b1;
            end else begin
               taddr_ff   <= obj_addr;
               sx_ff      <= list_entry.x;
               behind_ff  <= list_entry.flags[OBJ_BEHIND];
               xflip_ff   <= list_entry.flags[OBJ_XFLIP];
               obj_pal_ff <= list_entry.flags[OBJ_PAL1] ? obp1_ff : obp0_ff;
            end
         end
         S_OBJ_LO: lo_ff <= tram_rdata;
         S_OBJ_HI: begin
            hi_ff <= tram_rdata;
            px_ff <= '0;
         end
         S_OBJ_PX: begin
            if (px_ff == 4'd8) begin
               d_ff <= d_ff - 1'b1;
            end else if (on_line && sc != 2'd0) begin
               lbaddr_ff <= LBW'(pos9 - 9'd8);
               color_ff  <= sc;
            end else begin
               px_ff <= px_ff + 4'd1;
            end
         end
         S_OBJ_WR: px_ff <= px_ff + 4'd1;
         S_OUT: begin
            if (!p_end) begin
               pend_ff <= (ox_ff < OXW'(LINE_PIXELS));
               ox_ff   <= ox_ff + 1'b1;
            end
            if (p_ff != '0) packed_ff <= packed_next;
            if (p_end) begin
               rsp_ff.group  <= 5'(g_ff);
               rsp_ff.shades <= 16'(packed_next);
               rsp_ff.last   <= g_end;
               g_ff          <= g_ff + 1'b1;
               p_ff          <= '0;
            end else begin
               p_ff <= p_ff + 1'b1;
            end
         end
         default: ;
      endcase
      if (state_ff != S_OUT && state_in == S_OUT) begin
         g_ff  <= '0;
         p_ff  <= '0;
         ox_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_ALWAYS(a_rsp_from_output, clock, reset, !rsp_valid_ff || ($past(state_ff) == S_OUT))
   `ASSERT_ALWAYS(a_tile_write_quiet, clock, reset, !tram_we || (state_ff == S_CLEAR || state_ff == S_IDLE))
   `ASSERT_NEXT(a_line_ends_last, clock, reset, (state_ff == S_OUT) && (state_in == S_IDLE), rsp_valid_ff && rsp_ff.last)

endmodule

`default_nettype wire

// ===== hdl/tsr_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module tsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/tsr_sprite_list.sv =====
// Sorted list of the sprites found on the current line, ordered by x then by entry order.
`default_nettype none
`include "assert_macros.svh"

module tsr_sprite_list #(
   parameter int SLOTS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tsr_pkg::sprite_ctrl_type               ctrl,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_index,
   output tsr_pkg::sprite_entry_type              rd_entry,
   output logic [$clog2(SLOTS+1)-1:0]             count
);
   import tsr_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);

   sprite_entry_type slots_ff [SLOTS];
   logic [CW-1:0]    count_ff;
   logic [SLOTS-1:0] greater;

   // A slot holds a sprite placed right of the new one; such slots move up by one.
   genvar j;
   generate
      for (j = 0; j < SLOTS; j++) begin : g_slot
         assign greater[j] = (CW'(j) < count_ff) && (slots_ff[j].x > ctrl.entry.x);
         if (j == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (ctrl.push && (greater[j] || count_ff == CW'(j))) begin
                  slots_ff[j] <= ctrl.entry;
               end
            end
         end else begin : g_rest
            always_ff @(posedge clock) begin
               if (ctrl.push && (greater[j] || count_ff == CW'(j))) begin
                  slots_ff[j] <= greater[j-1] ? slots_ff[j-1] : ctrl.entry;
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.clear) begin
         count_ff <= '0;
      end else if (ctrl.push) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   assign rd_entry = slots_ff[rd_index];
   assign count    = count_ff;

   `ASSERT_ALWAYS(a_push_has_room, clock, reset, !ctrl.push || (count_ff < CW'(SLOTS)))

endmodule

`default_nettype wire
